>>> rtl/core/c_comment_stripper_unit_assert.svh
// Assertion macros for the comment stripper
`ifndef C_COMMENT_STRIPPER_UNIT_ASSERT_SVH
`define C_COMMENT_STRIPPER_UNIT_ASSERT_SVH

// same-cycle implication
`define CCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("comment stripper check failed");

// next-cycle implication
`define CCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("comment stripper check failed");

`endif

>>> rtl/core/ccs_pkg.sv
// Types and constants shared by the comment stripper modules
package ccs_pkg;

  typedef enum logic [2:0] {
    MODE_PLAIN     = 3'd0,
    MODE_SLASH     = 3'd1,
    MODE_LINE      = 3'd2,
    MODE_BLOCK     = 3'd3,
    MODE_BLOCKSTAR = 3'd4
  } mode_t;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       text_end;
  } entry_t;

  typedef struct packed {
    logic [1:0] cnt;
    entry_t     e0;
    entry_t     e1;
  } scan_out_t;

endpackage

>>> rtl/core/c_comment_stripper_unit.sv
// Comment stripper top level: removes line and block comments from a byte stream
//
//   channel | direction | payload                              | handshake
//   in      | input     | in_char, in_end                      | in_valid / in_stall
//   out     | output    | out_char, out_run_last, out_text_end | out_valid / out_stall
//
// One byte accepted per cycle while in_stall is low; each byte yields zero to two results.
// Results leave a four-entry queue one per cycle while out_stall is low, earliest in the cycle after the transfer.
// in_stall rises when the queue holds three or more results. Two-result bytes
// always follow a slash that yields none, so with out_stall low the queue holds
// at most two and the input never stalls.
// Synchronous reset empties the queue and returns the scanner to plain text.
module c_comment_stripper_unit
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       in_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_text_end
);

`include "c_comment_stripper_unit_assert.svh"

  logic       take;
  logic       full;
  scan_out_t  res;
  mode_t      mode;
  entry_t     head;
  logic [2:0] q_count;

  assign in_stall = full;
  assign take     = in_valid && !full;

  ccs_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .in_char (in_char),
    .in_end  (in_end),
    .res     (res),
    .mode    (mode)
  );

  ccs_rq u_rq (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .res   (res),
    .full  (full),
    .valid (out_valid),
    .stall (out_stall),
    .head  (head),
    .count (q_count)
  );

  assign out_char     = head.ch;
  assign out_run_last = head.run_last;
  assign out_text_end = head.text_end;

  `CCS_ASSERT_NOW(a_no_overflow, 1'b1, q_count <= 3'd4)
  `CCS_ASSERT_NEXT(a_end_plain, take && in_end, mode == MODE_PLAIN)
  `CCS_ASSERT_NOW(a_end_is_last, out_valid && out_text_end, out_run_last)

endmodule

>>> rtl/core/ccs_scan.sv
// Scanner: mode register and per-byte decode into zero to two results
module ccs_scan
  import ccs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] in_char,
  input  logic       in_end,
  output scan_out_t  res,
  output mode_t      mode
);

  mode_t      mode_next;
  logic [1:0] n;
  logic [7:0] b0;
  logic [7:0] b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_PLAIN;
    end else if (take) begin
      mode <= mode_next;
    end
  end

  always_comb begin
    n         = 2'd0;
    b0        = in_char;
    b1        = in_char;
    mode_next = mode;
    case (mode)
      MODE_SLASH: begin
        if (in_char == CH_SLASH) begin
          mode_next = MODE_LINE;
        end else if (in_char == CH_STAR) begin
          mode_next = MODE_BLOCK;
        end else begin
          mode_next = MODE_PLAIN;
          b0        = CH_SLASH;
          n         = 2'd2;
        end
      end
      MODE_LINE: begin
        if (in_char == CH_NEWLINE) begin
          mode_next = MODE_PLAIN;
          n         = 2'd1;
        end
      end
      MODE_BLOCK: begin
        mode_next = (in_char == CH_STAR) ? MODE_BLOCKSTAR : MODE_BLOCK;
        if (in_char == CH_NEWLINE) begin
          n = 2'd1;
        end
      end
      MODE_BLOCKSTAR: begin
        if (in_char == CH_SLASH) begin
          mode_next = MODE_PLAIN;
        end else if (in_char == CH_STAR) begin
          mode_next = MODE_BLOCKSTAR;
        end else begin
          mode_next = MODE_BLOCK;
          if (in_char == CH_NEWLINE) begin
            n = 2'd1;
          end
        end
      end
      default: begin
        if (in_char == CH_SLASH) begin
          mode_next = MODE_SLASH;
        end else begin
          mode_next = MODE_PLAIN;
          n         = 2'd1;
        end
      end
    endcase
    if (in_end) begin
      // held slash is flushed; nothing else was emitted in that case
      if (mode_next == MODE_SLASH) begin
        b0 = CH_SLASH;
        n  = 2'd1;
      end
      mode_next = MODE_PLAIN;
    end
  end

  always_comb begin
    res.cnt         = n;
    res.e0.ch       = b0;
    res.e0.run_last = (n == 2'd1);
    res.e0.text_end = (n == 2'd1) && in_end;
    res.e1.ch       = b1;
    res.e1.run_last = 1'b1;
    res.e1.text_end = in_end;
  end

endmodule

>>> rtl/core/ccs_rq.sv
// Four-entry result queue, takes up to two results per cycle while not full, drives the output
module ccs_rq
  import ccs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  scan_out_t res,
  output logic      full,
  output logic      valid,
  input  logic      stall,
  output entry_t    head,
  output logic [2:0] count
);

  entry_t     mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [1:0] add;
  logic       pop;

  assign pop   = valid && !stall;
  assign add   = push ? res.cnt : 2'd0;
  assign valid = (count != 3'd0);
  assign full  = (count > 3'd2);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && res.cnt != 2'd0) begin
      mem[wr_ptr] <= res.e0;
    end
    if (push && res.cnt == 2'd2) begin
      mem[wr_ptr + 2'd1] <= res.e1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + add;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, add} - {2'b00, pop};
    end
  end

endmodule
